@@ src/vft_pkg.sv @@
`timescale 1ns / 1ps

package vft_pkg;

  localparam int ENTRIES    = 64;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 31;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int USED_BITS  = $clog2(ENTRIES + 1);

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] sample_value;
  } vft_in_t;

  typedef struct packed {
    logic signed [31:0] mode_value;
    logic               mode_valid;
    logic [6:0]         distinct_count;
    logic               dropped_full;
  } vft_out_t;

endpackage

@@ src/value_frequency_table_mode_core.sv @@
`timescale 1ns / 1ps
// an add walks the used entries until a match, then bumps the count or appends the
// value and presents the result; a query walks all used entries before its result;
// clear and unused kinds go straight to the result; one table entry is read per cycle
// one transaction at a time: a new one is not accepted until the last result is loaded
// into the output register, as the memories have a single read port and are walked in order
// reset: synchronous active low, empties the table; memory contents are not cleared
module value_frequency_table_mode_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vft_pkg::vft_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vft_pkg::vft_out_t  out_data
);
  import vft_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_OUT
  } state_t;

  state_t                state_r;
  logic [1:0]            kind_r;
  logic [VALUE_BITS-1:0] sample_r;
  logic [USED_BITS-1:0]  used_r;
  logic [USED_BITS-1:0]  rd_idx_r;
  logic [USED_BITS-1:0]  cmp_idx_r;
  logic                  pipe_v_r;
  logic                  found_r;
  logic [IDX_BITS-1:0]   hit_idx_r;
  logic [COUNT_BITS-1:0] hit_cnt_r;
  logic [VALUE_BITS-1:0] best_v_r;
  logic [COUNT_BITS-1:0] best_c_r;
  logic                  dropped_r;
  logic                  out_valid_r;
  vft_out_t              out_data_r;

  logic [VALUE_BITS-1:0] value_mem [ENTRIES];
  logic [COUNT_BITS-1:0] count_mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_q;
  logic [COUNT_BITS-1:0] cnt_q;

  logic                  rd_go;
  logic                  hit;
  logic                  wr_en;
  logic [IDX_BITS-1:0]   wr_addr;
  logic [VALUE_BITS-1:0] wr_val;
  logic [COUNT_BITS-1:0] wr_cnt;
  logic                  wr_val_en;
  logic                  out_load;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rd_go    = (state_r == ST_SCAN) && (rd_idx_r < used_r);
  assign hit      = pipe_v_r && (kind_r == KIND_ADD) && (val_q == sample_r);
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  // one write port: count bump on a match, or append of a new value
  always_comb begin
    wr_en     = 1'b0;
    wr_val_en = 1'b0;
    wr_addr   = hit_idx_r;
    wr_val    = sample_r;
    wr_cnt    = hit_cnt_r;
    if (state_r == ST_WRITE) begin
      if (found_r) begin
        wr_en = 1'b1;
        if (hit_cnt_r != {COUNT_BITS{1'b1}}) begin
          wr_cnt = hit_cnt_r + COUNT_BITS'(1);
        end
      end else if (used_r < USED_BITS'(ENTRIES)) begin
        wr_en     = 1'b1;
        wr_val_en = 1'b1;
        wr_addr   = used_r[IDX_BITS-1:0];
        wr_cnt    = COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      count_mem[wr_addr] <= wr_cnt;
    end
    if (wr_val_en) begin
      value_mem[wr_addr] <= wr_val;
    end
    if (rd_go) begin
      val_q <= value_mem[rd_idx_r[IDX_BITS-1:0]];
      cnt_q <= count_mem[rd_idx_r[IDX_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      pipe_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            kind_r    <= in_data.kind;
            sample_r  <= VALUE_BITS'(in_data.sample_value);
            rd_idx_r  <= '0;
            pipe_v_r  <= 1'b0;
            found_r   <= 1'b0;
            dropped_r <= 1'b0;
            if (in_data.kind == KIND_ADD || in_data.kind == KIND_QUERY) begin
              state_r <= ST_SCAN;
            end else begin
              if (in_data.kind == KIND_CLEAR) begin
                used_r <= '0;
              end
              state_r <= ST_OUT;
            end
          end
        end
        ST_SCAN: begin
          pipe_v_r  <= rd_go && !hit;
          cmp_idx_r <= rd_idx_r;
          if (rd_go) begin
            rd_idx_r <= rd_idx_r + USED_BITS'(1);
          end
          if (pipe_v_r && kind_r == KIND_QUERY) begin
            if (cmp_idx_r == '0 || cnt_q > best_c_r) begin
              best_v_r <= val_q;
              best_c_r <= cnt_q;
            end
          end
          if (hit) begin
            // stop the walk, the read still in flight is discarded
            found_r   <= 1'b1;
            hit_idx_r <= cmp_idx_r[IDX_BITS-1:0];
            hit_cnt_r <= cnt_q;
            state_r   <= ST_WRITE;
          end else if (!rd_go && !pipe_v_r) begin
            state_r <= (kind_r == KIND_ADD) ? ST_WRITE : ST_OUT;
          end
        end
        ST_WRITE: begin
          if (!found_r) begin
            if (used_r < USED_BITS'(ENTRIES)) begin
              used_r <= used_r + USED_BITS'(1);
            end else begin
              dropped_r <= 1'b1;
            end
          end
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            out_data_r.distinct_count  <= 7'(used_r);
            out_data_r.dropped_full    <= dropped_r;
            if (kind_r == KIND_QUERY && used_r != '0) begin
              out_data_r.mode_value <= 32'($signed(best_v_r));
              out_data_r.mode_valid <= 1'b1;
            end else begin
              out_data_r.mode_value <= '0;
              out_data_r.mode_valid <= 1'b0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
